>>> hw/rtl/ssv_pkg.sv
// Shared types, codes and constants of the synth voice.
package ssv_pkg;

   localparam int FUNC_W   = 2;
   localparam int NOTE_W   = 8;
   localparam int VEL_W    = 16;
   localparam int SAMPLE_W = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // shared multiplier operand width (signed)
   localparam int MUL_W = 33;

   typedef logic [FUNC_W-1:0] func_type;
   typedef logic [2:0]        env_stage_type;

   localparam func_type FUNC_TICK     = 2'd0;
   localparam func_type FUNC_NOTE_ON  = 2'd1;
   localparam func_type FUNC_NOTE_OFF = 2'd2;

   localparam env_stage_type STG_IDLE    = 3'd0;
   localparam env_stage_type STG_ATTACK  = 3'd1;
   localparam env_stage_type STG_DECAY   = 3'd2;
   localparam env_stage_type STG_SUSTAIN = 3'd3;
   localparam env_stage_type STG_RELEASE = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_WAVEFORM  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEFF     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FEEDBACK  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SUSTAIN   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_REL_SCALE = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_LEVEL = 3'd7;

   localparam logic [31:0] ENV_ONE  = 32'h8000_0000;
   localparam logic [15:0] GAIN_ONE = 16'h8000;

   // Hz * 2^20 for the top octave, notes 116..127
   localparam logic [63:0] TOP_OCTAVE [12] = '{
      64'd6967656617,  64'd7381975040,  64'd7820930118,  64'd8285986824,
      64'd8778697241,  64'd9300705742,  64'd9853754486,  64'd10439688991,
      64'd11060465444, 64'd11718154944, 64'd12414952698, 64'd13153184201
   };

endpackage

>>> hw/rtl/ssv_req_if.sv
// Request channel: tick and note events into the voice.
interface ssv_req_if;
   import ssv_pkg::*;

   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [NOTE_W-1:0] note;
   logic [VEL_W-1:0]  velocity;

   modport source (output valid, func, note, velocity, input ready);
   modport sink   (input valid, func, note, velocity, output ready);
endinterface

>>> hw/rtl/ssv_rsp_if.sv
// Response channel: one output sample per request.
interface ssv_rsp_if;
   import ssv_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       active;

   modport source (output valid, sample, active, input ready);
   modport sink   (input valid, sample, active, output ready);
endinterface

>>> hw/rtl/ssv_mul.sv
// Shared signed multiplier with a registered product.
module ssv_mul (
   input  logic                              clock,
   input  logic signed [ssv_pkg::MUL_W-1:0]   a,
   input  logic signed [ssv_pkg::MUL_W-1:0]   b,
   output logic signed [2*ssv_pkg::MUL_W-1:0] p
);
   import ssv_pkg::*;

   logic signed [2*MUL_W-1:0] p_ff;
   logic signed [2*MUL_W-1:0] p_in;

   assign p_in = (2*MUL_W)'(a) * (2*MUL_W)'(b);

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   assign p = p_ff;
endmodule

>>> hw/rtl/subtractive_synth_voice_core.sv
// Request sequence: note-on goes to S_FIN; note-off runs S_REL, S_RELW, S_FIN; a silent
// tick runs S_ENV, S_FIN; a sounding tick runs S_ENV, S_OSC to S_G4, S_FIN,
// with S_REL, S_RELW after S_ENV when the envelope leaves sustain. One request at a time;
// the next is taken the cycle after the result is parked in the output register.
// Reset (synchronous): control registers return to defaults, work data is not reset;
// voice idle at note 69 pitch, phase, filter and envelope cleared; no clearing pass.
module subtractive_synth_voice_core #(
   parameter int SAMPLE_RATE = 48000,
   parameter int PHASE_BITS  = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   ssv_req_if.sink                            req_if,
   ssv_rsp_if.source                          rsp_if,
   input  logic                               csr_wr_en,
   input  logic [ssv_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ssv_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import ssv_pkg::*;

   typedef logic [PHASE_BITS-1:0] step_arr_type [128];

   function automatic step_arr_type build_steps();
      step_arr_type tbl;
      logic [63:0]  f;
      logic [63:0]  q;
      int unsigned  d;
      for (int n = 0; n < 128; n++) begin
         d = 127 - n;
         f = TOP_OCTAVE[11 - (d % 12)] >> (d / 12);
         q = (f << (PHASE_BITS - 12)) / 64'(SAMPLE_RATE);
         tbl[n] = PHASE_BITS'((q + 64'd128) >> 8);
      end
      return tbl;
   endfunction

   localparam step_arr_type STEP_TABLE = build_steps();
   localparam int A4_NOTE = 69;

   // sequencer codes
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_ENV  = 4'd1;
   localparam logic [3:0] S_REL  = 4'd2;
   localparam logic [3:0] S_RELW = 4'd3;
   localparam logic [3:0] S_OSC  = 4'd4;
   localparam logic [3:0] S_FBK  = 4'd5;
   localparam logic [3:0] S_DIF  = 4'd6;
   localparam logic [3:0] S_FIL  = 4'd7;
   localparam logic [3:0] S_G1   = 4'd8;
   localparam logic [3:0] S_G2   = 4'd9;
   localparam logic [3:0] S_G3   = 4'd10;
   localparam logic [3:0] S_G4   = 4'd11;
   localparam logic [3:0] S_FIN  = 4'd12;

   logic [3:0] state_ff, state_in;

   // configuration
   logic        waveform_ff, waveform_in;
   logic [15:0] coeff_ff, coeff_in;
   logic [14:0] feedback_ff, feedback_in;
   logic [31:0] attack_ff, attack_in;
   logic [31:0] decay_ff, decay_in;
   logic [31:0] sustain_ff, sustain_in;
   logic [31:0] rscale_ff, rscale_in;
   logic [15:0] out_level_ff, out_level_in;

   // voice state
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [PHASE_BITS-1:0] phase_step_ff, phase_step_in;
   logic signed [15:0]    z_ff, z_in;
   logic [31:0]           env_level_ff, env_level_in;
   env_stage_type         env_stage_ff, env_stage_in;
   logic [31:0]           env_step_ff, env_step_in;
   logic                  gate_ff, gate_in;
   logic [VEL_W-1:0]      velocity_ff, velocity_in;

   // work registers
   logic                       tick_ff, tick_in;
   logic signed [15:0]         osc_ff, osc_in;
   logic signed [17:0]         dif_ff, dif_in;
   logic signed [SAMPLE_W-1:0] res_sample_ff, res_sample_in;
   logic                       res_active_ff, res_active_in;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                       rsp_active_ff, rsp_active_in;

   // shared multiplier
   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic signed [2*MUL_W-1:0] mul_p;

   // datapath terms
   logic                req_xfer;
   logic                rsp_free;
   logic [31:0]         sus_val;
   logic [32:0]         att_sum;
   logic signed [33:0]  env_dif;
   logic [31:0]         rel_step;
   logic signed [15:0]  osc_val;
   logic signed [15:0]  fb_val;
   logic [15:0]         coeff_c;
   logic [15:0]         gain_c;
   logic signed [19:0]  flt_sum;
   logic signed [15:0]  z_clamp;

   ssv_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .p     (mul_p)
   );

   assign req_if.ready  = (state_ff == S_IDLE);
   assign req_xfer      = req_if.valid && (state_ff == S_IDLE);
   assign rsp_free      = !rsp_valid_ff || rsp_if.ready;
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.sample = rsp_sample_ff;
   assign rsp_if.active = rsp_active_ff;

   assign sus_val  = (sustain_ff > ENV_ONE) ? ENV_ONE : sustain_ff;
   assign att_sum  = {1'b0, env_level_ff} + {1'b0, env_step_ff};
   assign env_dif  = $signed({2'b00, env_level_ff}) - $signed({2'b00, env_step_ff});
   // ceiling of level * scale / 2^32
   assign rel_step = mul_p[63:32] + 32'(|mul_p[31:0]);

   assign osc_val = waveform_ff ?
                    (phase_ff[PHASE_BITS-1] ? 16'sh8000 : 16'sh7fff) :
                    $signed({~phase_ff[PHASE_BITS-1], phase_ff[PHASE_BITS-2 -: 15]});

   assign fb_val  = $signed(mul_p[30:15]);
   assign coeff_c = (coeff_ff > GAIN_ONE) ? GAIN_ONE : coeff_ff;
   assign gain_c  = (out_level_ff > GAIN_ONE) ? GAIN_ONE : out_level_ff;
   assign flt_sum = 20'(z_ff) + 20'($signed(mul_p[33:15]));

   always_comb begin
      if (flt_sum > 20'sd32767) begin
         z_clamp = 16'sh7fff;
      end else if (flt_sum < -20'sd32768) begin
         z_clamp = 16'sh8000;
      end else begin
         z_clamp = flt_sum[15:0];
      end
   end

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_REL: begin
            mul_a = MUL_W'(env_level_ff);
            mul_b = MUL_W'(rscale_ff);
         end
         S_OSC: begin
            mul_a = MUL_W'(z_ff);
            mul_b = MUL_W'(feedback_ff);
         end
         S_DIF: begin
            mul_a = MUL_W'(coeff_c);
            mul_b = MUL_W'(dif_ff);
         end
         S_G1: begin
            mul_a = MUL_W'(z_ff);
            mul_b = MUL_W'(env_level_ff);
         end
         S_G2: begin
            mul_a = MUL_W'($signed(mul_p[46:31]));
            mul_b = MUL_W'(velocity_ff);
         end
         S_G3: begin
            mul_a = MUL_W'($signed(mul_p[30:15]));
            mul_b = MUL_W'(gain_c);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // configuration writes
   always_comb begin
      waveform_in  = waveform_ff;
      coeff_in     = coeff_ff;
      feedback_in  = feedback_ff;
      attack_in    = attack_ff;
      decay_in     = decay_ff;
      sustain_in   = sustain_ff;
      rscale_in    = rscale_ff;
      out_level_in = out_level_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_WAVEFORM:  waveform_in  = csr_wdata[0];
            CSR_COEFF:     coeff_in     = csr_wdata[15:0];
            CSR_FEEDBACK:  feedback_in  = csr_wdata[14:0];
            CSR_ATTACK:    attack_in    = csr_wdata;
            CSR_DECAY:     decay_in     = csr_wdata;
            CSR_SUSTAIN:   sustain_in   = csr_wdata;
            CSR_REL_SCALE: rscale_in    = csr_wdata;
            CSR_OUT_LEVEL: out_level_in = csr_wdata[15:0];
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      phase_step_in = phase_step_ff;
      z_in          = z_ff;
      env_level_in  = env_level_ff;
      env_stage_in  = env_stage_ff;
      env_step_in   = env_step_ff;
      gate_in       = gate_ff;
      velocity_in   = velocity_ff;
      tick_in       = tick_ff;
      osc_in        = osc_ff;
      dif_in        = dif_ff;
      res_sample_in = res_sample_ff;
      res_active_in = res_active_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_active_in = rsp_active_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               res_sample_in = '0;
               res_active_in = 1'b0;
               tick_in       = (req_if.func == FUNC_TICK);
               priority case (req_if.func)
                  FUNC_TICK: begin
                     state_in = S_ENV;
                  end
                  FUNC_NOTE_ON: begin
                     velocity_in = (req_if.velocity > GAIN_ONE) ? GAIN_ONE : req_if.velocity;
                     if (!req_if.note[NOTE_W-1]) begin
                        phase_step_in = STEP_TABLE[req_if.note[6:0]];
                     end
                     gate_in      = 1'b1;
                     env_stage_in = STG_ATTACK;
                     env_step_in  = attack_ff;
                     state_in     = S_FIN;
                  end
                  FUNC_NOTE_OFF: begin
                     state_in = S_REL;
                  end
                  default: begin
                     state_in = S_FIN;
                  end
               endcase
            end
         end
         S_ENV: begin
            state_in = S_OSC;
            unique case (env_stage_ff)
               STG_ATTACK: begin
                  if (att_sum >= {1'b0, ENV_ONE}) begin
                     env_level_in = ENV_ONE;
                     env_stage_in = STG_DECAY;
                     env_step_in  = decay_ff;
                  end else begin
                     env_level_in = att_sum[31:0];
                  end
               end
               STG_DECAY: begin
                  if (env_dif <= $signed({2'b00, sus_val})) begin
                     env_level_in = sus_val;
                     env_stage_in = STG_SUSTAIN;
                  end else begin
                     env_level_in = env_dif[31:0];
                  end
               end
               STG_SUSTAIN: begin
                  env_level_in = sus_val;
                  if (!gate_ff) begin
                     state_in = S_REL;
                  end
               end
               STG_RELEASE: begin
                  if (env_dif <= 34'sd0) begin
                     env_level_in = '0;
                     env_stage_in = STG_IDLE;
                     state_in     = S_FIN;
                  end else begin
                     env_level_in = env_dif[31:0];
                  end
               end
               default: begin
                  env_level_in = '0;
                  env_stage_in = STG_IDLE;
                  state_in     = S_FIN;
               end
            endcase
         end
         S_REL: begin
            state_in = S_RELW;
         end
         S_RELW: begin
            env_step_in  = rel_step;
            env_stage_in = STG_RELEASE;
            gate_in      = 1'b0;
            state_in     = tick_ff ? S_OSC : S_FIN;
         end
         S_OSC: begin
            osc_in   = osc_val;
            phase_in = phase_ff + phase_step_ff;
            state_in = S_FBK;
         end
         S_FBK: begin
            dif_in   = 18'(osc_ff) - 18'(z_ff) + 18'(fb_val);
            state_in = S_DIF;
         end
         S_DIF: begin
            state_in = S_FIL;
         end
         S_FIL: begin
            z_in     = z_clamp;
            state_in = S_G1;
         end
         S_G1: begin
            state_in = S_G2;
         end
         S_G2: begin
            state_in = S_G3;
         end
         S_G3: begin
            state_in = S_G4;
         end
         S_G4: begin
            // product stays inside Q1.15 range, no clamp needed
            res_sample_in = $signed(mul_p[30:15]);
            res_active_in = 1'b1;
            state_in      = S_FIN;
         end
         S_FIN: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = res_sample_ff;
               rsp_active_in = res_active_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         waveform_ff   <= 1'b0;
         coeff_ff      <= 16'd4766;
         feedback_ff   <= 15'd6226;
         attack_ff     <= 32'd2130440;
         decay_ff      <= 32'd32736;
         sustain_ff    <= 32'd1503238554;
         rscale_ff     <= 32'd98328;
         out_level_ff  <= 16'd13107;
         phase_ff      <= '0;
         phase_step_ff <= STEP_TABLE[A4_NOTE];
         z_ff          <= '0;
         env_level_ff  <= '0;
         env_stage_ff  <= STG_IDLE;
         env_step_ff   <= '0;
         gate_ff       <= 1'b0;
         velocity_ff   <= '0;
         tick_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         waveform_ff   <= waveform_in;
         coeff_ff      <= coeff_in;
         feedback_ff   <= feedback_in;
         attack_ff     <= attack_in;
         decay_ff      <= decay_in;
         sustain_ff    <= sustain_in;
         rscale_ff     <= rscale_in;
         out_level_ff  <= out_level_in;
         phase_ff      <= phase_in;
         phase_step_ff <= phase_step_in;
         z_ff          <= z_in;
         env_level_ff  <= env_level_in;
         env_stage_ff  <= env_stage_in;
         env_step_ff   <= env_step_in;
         gate_ff       <= gate_in;
         velocity_ff   <= velocity_in;
         tick_ff       <= tick_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      osc_ff        <= osc_in;
      dif_ff        <= dif_in;
      res_sample_ff <= res_sample_in;
      res_active_ff <= res_active_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_active_ff <= rsp_active_in;
   end

endmodule

>>> hw/rtl/ssv_checker.sv
// Port-level checks on the voice core, bound into the voice core module.
module ssv_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [ssv_pkg::SAMPLE_W-1:0] rsp_sample,
   input logic                                rsp_active
);
   import ssv_pkg::*;

   // output register is empty out of reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // one request in flight: no back-to-back request transfer
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // a silent result carries a zero sample
   a_silent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_active |-> rsp_sample == '0)
      else $error("inactive response with nonzero sample");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample) && $stable(rsp_active))
      else $error("response changed under stall");

endmodule

bind subtractive_synth_voice_core ssv_checker u_ssv_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_if.valid),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .rsp_sample (rsp_if.sample),
   .rsp_active (rsp_if.active)
);
